/* sv/arpc_pkg.sv */
// ARP cache package: command and result codes, entry and item types, defaults.
// No dependencies; used by every file of the ARP cache.
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PORT_COUNT        = 4;

    localparam logic [15:0] TTL_RESET    = 16'd300;
    localparam logic [15:0] PERIOD_RESET = 16'd10;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_LOOKUP  = 3'd0;
    localparam logic [2:0] KIND_SET     = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_REFRESH = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    // register indexes
    localparam logic REG_TTL    = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  port;
        logic [31:0] created;
        logic [7:0]  tries;
    } t_entry;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] addr_ip;
        logic [47:0] hw_addr;
        logic [1:0]  port;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [5:0]  slot;
        logic [47:0] entry_hw_addr;
        logic [1:0]  entry_port;
        logic [7:0]  entry_tries;
        logic [31:0] request_ip;
        logic        final_flag;
    } t_result;

    // head evaluation status
    typedef struct packed {
        logic take;     // this slot is the first hit or first empty one
        logic hit;      // slot holds the address
        logic refresh;  // entry aged out, request goes out
    } t_head_sts;

    localparam t_entry ENTRY_EMPTY = '0;

endpackage

/* sv/arpc_cell.sv */
// ARP cache cell: one table entry in the shifting ring.
// Depends on arpc_pkg.
module arpc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  arpc_pkg::t_entry i_d,
    output arpc_pkg::t_entry o_q
);

    arpc_pkg::t_entry r_entry;
    arpc_pkg::t_entry n_entry;

    always_comb begin
        n_entry = i_shift ? i_d : r_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= arpc_pkg::ENTRY_EMPTY;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_q = r_entry;

endmodule

/* sv/arpc_head.sv */
// ARP cache head logic: evaluates the entry at the ring head and forms its write-back.
// Depends on arpc_pkg.
module arpc_head (
    input  logic                [1:0]  i_op,
    input  arpc_pkg::t_entry           i_entry,
    input  logic                [31:0] i_ip,
    input  logic                [47:0] i_mac,
    input  logic                [1:0]  i_port,
    input  logic                [31:0] i_now,
    input  logic                [15:0] i_ttl,
    input  logic                       i_found,
    output arpc_pkg::t_entry           o_wb,
    output arpc_pkg::t_head_sts        o_sts
);

    logic [31:0] age;
    logic        older;
    logic        same_ip;
    logic        empty;
    logic        match;
    logic [4:0]  port_ext;
    logic [1:0]  port_clamp;

    always_comb begin
        age      = i_now - i_entry.created;
        empty    = (i_entry.ip == 32'd0);
        same_ip  = (i_entry.ip == i_ip);
        older    = !empty && (age > {16'd0, i_ttl});
        match    = !i_found && (same_ip || empty);
        port_ext = {3'b000, i_port};
        if (port_ext >= 5'(arpc_pkg::PORT_COUNT)) begin
            port_clamp = 2'(arpc_pkg::PORT_COUNT - 1);
        end else begin
            port_clamp = i_port;
        end

        o_wb  = i_entry;
        o_sts = '0;
        unique case (i_op)
            arpc_pkg::CMD_LOOKUP: begin
                o_sts.take = match;
                o_sts.hit  = (i_ip != 32'd0) && same_ip;
            end
            arpc_pkg::CMD_SET: begin
                o_sts.take = match;
                o_sts.hit  = same_ip;
                if (match) begin
                    o_wb.ip      = i_ip;
                    o_wb.mac     = i_mac;
                    o_wb.port    = port_clamp;
                    o_wb.created = i_now;
                    o_wb.tries   = 8'd0;
                end
            end
            arpc_pkg::CMD_TICK: begin
                o_sts.refresh = older;
                if (older && (i_entry.tries != 8'hFF)) begin
                    o_wb.tries = i_entry.tries + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/arp_cache_with_aging_unit.sv */
// ARP cache with aging (uses arpc_pkg, arpc_cell, arpc_head): entry ring, sequencer, APB regs.
// A lookup/set result is built in r_cap as the N slots pass the head, then goes out via r_emit
// and r_out, as does a zero-address set or non-checking tick; a refresh goes via r_out as its
// slot passes the head, the tick marker after the scan. A lookup, set or checking tick is busy
// while the ring passes one slot per cycle under the head; other items one per cycle. Results
// cannot be stalled. Sync active-low reset clears table and seconds count, resets registers.
module arp_cache_with_aging_unit #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  arpc_pkg::t_item   i_item,
    // result channel: one cycle strobe, no back-pressure
    output logic              o_valid,
    output arpc_pkg::t_result o_result,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0] r_ttl;
    logic [15:0] r_period;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl    <= arpc_pkg::TTL_RESET;
            r_period <= arpc_pkg::PERIOD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == arpc_pkg::REG_TTL) begin
                r_ttl <= pwdata[15:0];
            end else begin
                r_period <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == arpc_pkg::REG_TTL) ? {16'd0, r_ttl} : {16'd0, r_period};

    // ---------------------------------------------------------------
    // Entry ring: cell 0 is the head, the write-back enters the tail.
    // After N shifts every entry is back in its own slot.
    // ---------------------------------------------------------------
    arpc_pkg::t_entry    cell_q [TABLE_ENTRIES];
    arpc_pkg::t_entry    head_wb;
    arpc_pkg::t_head_sts head_sts;
    logic                shift;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        arpc_pkg::t_entry cell_d;
        if (k == TABLE_ENTRIES - 1) begin : g_tail
            assign cell_d = head_wb;
        end else begin : g_mid
            assign cell_d = cell_q[k+1];
        end
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     (cell_d),
            .o_q     (cell_q[k])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    logic              r_state,  n_state;
    logic [IDX_W-1:0]  r_idx,    n_idx;
    logic              r_found,  n_found;
    logic              r_emit,   n_emit;   // final result goes out next edge
    logic              r_valid,  n_valid;
    logic [31:0]       r_now,    n_now;
    logic [31:0]       r_last,   n_last;
    // payload
    logic [1:0]        r_op,     n_op;
    logic [31:0]       r_ip,     n_ip;
    logic [47:0]       r_mac,    n_mac;
    logic [1:0]        r_port,   n_port;
    arpc_pkg::t_result r_cap,    n_cap;    // final result being built
    arpc_pkg::t_result r_out,    n_out;

    logic        accept;
    logic [31:0] now_inc;
    logic        check_due;

    assign busy   = (r_state == ST_SCAN);
    assign accept = start && !busy;
    assign shift  = (r_state == ST_SCAN);

    arpc_head u_head (
        .i_op    (r_op),
        .i_entry (cell_q[0]),
        .i_ip    (r_ip),
        .i_mac   (r_mac),
        .i_port  (r_port),
        .i_now   (r_now),
        .i_ttl   (r_ttl),
        .i_found (r_found),
        .o_wb    (head_wb),
        .o_sts   (head_sts)
    );

    always_comb begin
        now_inc   = r_now + 32'd1;
        check_due = ((now_inc - r_last) >= {16'd0, r_period});

        n_state = r_state;
        n_idx   = r_idx;
        n_found = r_found;
        n_emit  = 1'b0;
        n_valid = 1'b0;
        n_now   = r_now;
        n_last  = r_last;
        n_op    = r_op;
        n_ip    = r_ip;
        n_mac   = r_mac;
        n_port  = r_port;
        n_cap   = r_cap;
        n_out   = r_out;

        // pending final result; never coincides with a refresh transfer
        if (r_emit) begin
            n_out   = r_cap;
            n_valid = 1'b1;
        end

        if (accept) begin
            n_op    = i_item.command;
            n_ip    = i_item.addr_ip;
            n_mac   = i_item.hw_addr;
            n_port  = i_item.port;
            n_idx   = '0;
            n_found = 1'b0;
            n_cap   = '0;
            n_cap.final_flag = 1'b1;
            unique case (i_item.command)
                arpc_pkg::CMD_LOOKUP: begin
                    n_cap.kind = arpc_pkg::KIND_FULL;
                    n_state    = ST_SCAN;
                end
                arpc_pkg::CMD_SET: begin
                    if (i_item.addr_ip == 32'd0) begin
                        n_cap.kind = arpc_pkg::KIND_SET;
                        n_emit     = 1'b1;
                    end else begin
                        n_cap.kind = arpc_pkg::KIND_FULL;
                        n_state    = ST_SCAN;
                    end
                end
                arpc_pkg::CMD_TICK: begin
                    n_cap.kind = arpc_pkg::KIND_TICK;
                    n_now      = now_inc;
                    if (check_due) begin
                        n_last  = now_inc;
                        n_state = ST_SCAN;
                    end else begin
                        n_emit = 1'b1;
                    end
                end
                default: begin
                    // unused command: no transfer
                end
            endcase
        end

        if (r_state == ST_SCAN) begin
            n_idx = r_idx + IDX_W'(1);
            if (head_sts.take) begin
                n_found                = 1'b1;
                n_cap.kind             = (r_op == arpc_pkg::CMD_SET) ? arpc_pkg::KIND_SET
                                                                     : arpc_pkg::KIND_LOOKUP;
                n_cap.hit              = head_sts.hit;
                n_cap.slot             = 6'(r_idx);
                n_cap.entry_hw_addr    = head_wb.mac;
                n_cap.entry_port       = head_wb.port;
                n_cap.entry_tries      = head_wb.tries;
                n_cap.request_ip       = 32'd0;
                n_cap.final_flag       = 1'b1;
            end
            if (head_sts.refresh) begin
                n_out.kind          = arpc_pkg::KIND_REFRESH;
                n_out.hit           = 1'b0;
                n_out.slot          = 6'(r_idx);
                n_out.entry_hw_addr = head_wb.mac;
                n_out.entry_port    = head_wb.port;
                n_out.entry_tries   = head_wb.tries;
                n_out.request_ip    = head_wb.ip;
                n_out.final_flag    = 1'b0;
                n_valid             = 1'b1;
            end
            if (r_idx == IDX_LAST) begin
                n_state = ST_IDLE;
                n_emit  = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_emit  <= 1'b0;
            r_valid <= 1'b0;
            r_now   <= 32'd0;
            r_last  <= 32'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_emit  <= n_emit;
            r_valid <= n_valid;
            r_now   <= n_now;
            r_last  <= n_last;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ip   <= n_ip;
        r_mac  <= n_mac;
        r_port <= n_port;
        r_cap  <= n_cap;
        r_out  <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

/* sv/arpc_checker.sv */
// ARP cache port checker and its bind onto the top level.
// Depends on arpc_pkg and arp_cache_with_aging_unit.
module arpc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input arpc_pkg::t_item   i_item,
    input logic              o_valid,
    input arpc_pkg::t_result o_result,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [2:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // only refresh requests are non-final
    a_nonfinal_is_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.final_flag |-> o_result.kind == arpc_pkg::KIND_REFRESH)
        else $error("non-final result that is not a refresh request");

    // end of a scan is followed by the final transfer
    a_scan_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |=> o_valid && o_result.final_flag)
        else $error("scan ended without final transfer");

    // refresh requests come out of a scan
    a_refresh_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == arpc_pkg::KIND_REFRESH |-> $past(busy))
        else $error("refresh transfer outside a scan");

endmodule

bind arp_cache_with_aging_unit arpc_checker u_arpc_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for arp_cache_with_aging_unit: lookups, sets, ticks and aging.
// Needs arpc_pkg and the unit itself; an in-bench table model predicts every result.
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOTS = arpc_pkg::TABLE_ENTRIES_DEF;
    // settle wait: longer than the slowest result, which follows a full scan of NSLOTS slots
    localparam int SETTLE_CYCLES = NSLOTS + 4;
    localparam int POOL = 20;
    // command 3 has no meaning; the unit drops it without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // ---------------------------------------------------------------
    // clock, reset and DUT ports (all inputs known from time zero)
    // ---------------------------------------------------------------
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    arpc_pkg::t_item   item_bus = '0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic              busy;
    logic              o_valid;
    arpc_pkg::t_result result_bus;
    logic [31:0]       prdata;
    logic              pready;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    arp_cache_with_aging_unit #(.TABLE_ENTRIES(NSLOTS)) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_bus),
        .o_valid  (o_valid),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ---------------------------------------------------------------
    // table model: the bench's own copy of the cache and its registers
    // ---------------------------------------------------------------
    logic [31:0] tbl_ip    [NSLOTS];
    logic [47:0] tbl_mac   [NSLOTS];
    logic [1:0]  tbl_port  [NSLOTS];
    logic [31:0] tbl_born  [NSLOTS];
    logic [7:0]  tbl_tries [NSLOTS];
    logic [31:0] clock_s    = '0;
    logic [31:0] last_sweep = '0;
    logic [15:0] ttl_cfg    = arpc_pkg::TTL_RESET;
    logic [15:0] period_cfg = arpc_pkg::PERIOD_RESET;

    arpc_pkg::t_result answers_due[$];   // results still owed by the unit, oldest first
    logic [31:0]       ip_pool[POOL];    // addresses the random traffic keeps reusing
    logic              steady = 1'b0;    // when set, items go back to back

    int fail_count     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int refreshes_seen = 0;
    int full_seen      = 0;

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
            tbl_port[i]  = '0;
            tbl_born[i]  = '0;
            tbl_tries[i] = '0;
        end
    end

    // first slot holding ip, else first empty slot; -1 when the table is full
    function automatic int slot_for(logic [31:0] ip);
        for (int i = 0; i < NSLOTS; i++)
            if (tbl_ip[i] == ip || tbl_ip[i] == '0) return i;
        return -1;
    endfunction

    // apply one accepted item to the table model and queue what it must answer
    function automatic void predict_arp(arpc_pkg::t_item it);
        arpc_pkg::t_result r;
        int                s;
        logic [31:0]       age;
        logic [1:0]        prt;
        r = '0;
        r.final_flag = 1'b1;
        case (it.command)
            arpc_pkg::CMD_LOOKUP: begin
                s = slot_for(it.addr_ip);
                if (s < 0) begin
                    r.kind = arpc_pkg::KIND_FULL;
                end else begin
                    // zero address lands on the first empty slot, never a hit
                    r.kind          = arpc_pkg::KIND_LOOKUP;
                    r.hit           = (it.addr_ip != '0) && (tbl_ip[s] == it.addr_ip);
                    r.slot          = s[5:0];
                    r.entry_hw_addr = tbl_mac[s];
                    r.entry_port    = tbl_port[s];
                    r.entry_tries   = tbl_tries[s];
                end
                answers_due.push_back(r);
            end
            arpc_pkg::CMD_SET: begin
                s = (it.addr_ip == '0) ? NSLOTS : slot_for(it.addr_ip);
                if (it.addr_ip == '0) begin
                    // zero address: plain set-done marker, nothing written
                    r.kind = arpc_pkg::KIND_SET;
                end else if (s < 0) begin
                    r.kind = arpc_pkg::KIND_FULL;
                end else begin
                    prt = (it.port >= arpc_pkg::PORT_COUNT) ?
                          2'(arpc_pkg::PORT_COUNT - 1) : it.port;
                    r.kind          = arpc_pkg::KIND_SET;
                    r.hit           = (tbl_ip[s] == it.addr_ip);
                    r.slot          = s[5:0];
                    r.entry_hw_addr = it.hw_addr;
                    r.entry_port    = prt;
                    tbl_ip[s]    = it.addr_ip;
                    tbl_mac[s]   = it.hw_addr;
                    tbl_port[s]  = prt;
                    tbl_born[s]  = clock_s;
                    tbl_tries[s] = '0;
                end
                answers_due.push_back(r);
            end
            arpc_pkg::CMD_TICK: begin
                clock_s = clock_s + 32'd1;
                age = clock_s - last_sweep;
                if (age >= {16'b0, period_cfg}) begin
                    for (int i = 0; i < NSLOTS; i++) begin
                        age = clock_s - tbl_born[i];
                        if (tbl_ip[i] != '0 && age > {16'b0, ttl_cfg}) begin
                            if (tbl_tries[i] != 8'hFF) tbl_tries[i] = tbl_tries[i] + 8'd1;
                            r               = '0;
                            r.kind          = arpc_pkg::KIND_REFRESH;
                            r.slot          = 6'(i);
                            r.entry_hw_addr = tbl_mac[i];
                            r.entry_port    = tbl_port[i];
                            r.entry_tries   = tbl_tries[i];
                            r.request_ip    = tbl_ip[i];
                            answers_due.push_back(r);
                        end
                    end
                    last_sweep = clock_s;
                end
                r            = '0;
                r.kind       = arpc_pkg::KIND_TICK;
                r.final_flag = 1'b1;
                answers_due.push_back(r);
            end
            default: ;  // unused command: no change, no result
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result checker: every strobe is one transfer, compared in order
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin
        arpc_pkg::t_result want;
        if (rst_n && o_valid === 1'b1) begin
            if (answers_due.size() == 0) begin
                $error("result with nothing expected: kind %0d slot %0d",
                       result_bus.kind, result_bus.slot);
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                results_seen++;
                if (want.kind == arpc_pkg::KIND_REFRESH) refreshes_seen++;
                if (want.kind == arpc_pkg::KIND_FULL) full_seen++;
                check_field("kind", 64'(want.kind), 64'(result_bus.kind));
                check_field("hit", 64'(want.hit), 64'(result_bus.hit));
                check_field("slot", 64'(want.slot), 64'(result_bus.slot));
                check_field("entry_hw_addr", 64'(want.entry_hw_addr),
                            64'(result_bus.entry_hw_addr));
                check_field("entry_port", 64'(want.entry_port), 64'(result_bus.entry_port));
                check_field("entry_tries", 64'(want.entry_tries),
                            64'(result_bus.entry_tries));
                check_field("request_ip", 64'(want.request_ip), 64'(result_bus.request_ip));
                check_field("final_flag", 64'(want.final_flag), 64'(result_bus.final_flag));
            end
        end
    end

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------
    function automatic arpc_pkg::t_item mk_item(logic [1:0] cmd, logic [31:0] ip,
                                                logic [47:0] mac, logic [1:0] prt);
        arpc_pkg::t_item it;
        it.command = cmd;
        it.addr_ip = ip;
        it.hw_addr = mac;
        it.port    = prt;
        return it;
    endfunction

    // One command transfer. start is left high afterwards so a back-to-back
    // follower never sees it dropped and raised within one time step; the
    // next send or settle decides what happens to it.
    task automatic send_item(arpc_pkg::t_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        item_bus <= it;
        do @(posedge clk); while (busy !== 1'b0);
        predict_arp(it);
        items_sent++;
    endtask

    // drop start, let every owed result come out, then wait out the settle time
    task automatic settle();
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write on an idle unit, then read back through the same port
    task automatic write_reg(logic idx, logic [15:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (idx == arpc_pkg::REG_TTL) ttl_cfg = val;
        else                          period_cfg = val;
        // read-back: new setup phase, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        check_field("prdata", 64'({16'b0, val}), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic arpc_pkg::t_item random_item();
        arpc_pkg::t_item it;
        int              pick;
        logic [63:0]     wide;
        wide       = {$urandom, $urandom};
        it.hw_addr = wide[47:0];
        it.port    = 2'($urandom_range(3));
        pick = $urandom_range(99);
        it.command = (pick < 38) ? arpc_pkg::CMD_LOOKUP :
                     (pick < 70) ? arpc_pkg::CMD_SET :
                     (pick < 96) ? arpc_pkg::CMD_TICK : CMD_UNUSED;
        // mostly pool addresses so hits, overwrites and a full table all occur
        pick = $urandom_range(99);
        it.addr_ip = (pick < 88) ? ip_pool[$urandom_range(POOL - 1)] :
                     (pick < 96) ? 32'($urandom) : 32'h0;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty table: misses land on slot 0, zero addresses, unused command
    task automatic test_empty_table();
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0000_0001, '1, 2'd3));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0, '1, 2'd3));
        send_item(mk_item(CMD_UNUSED, 32'hFFFF_FFFF, '1, 2'd3));
    endtask

    // writes, hits, overwrite, every port value, extreme addresses
    task automatic test_set_and_lookup();
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0000_0001, '1, 2'd3));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'hFFFF_FFFF, 48'h0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'hC0A8_0101, 48'hA5A5_5A5A_0F0F, 2'd1));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0A0A_0A0A, 48'h5A5A_A5A5_F0F0, 2'd2));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0000_0001, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'hC0A8_0101, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0000_0001, 48'h1234_5678_9ABC, 2'd2));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0000_0001, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0, '0, 2'd0));
    endtask

    // default registers: no check before ten seconds, nothing old enough after
    task automatic test_tick_without_check();
        repeat (10) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
    endtask

    // short ttl: entries age out and tries climb; a set clears them again
    task automatic test_aging_refresh();
        write_reg(arpc_pkg::REG_TTL, 16'd2);
        write_reg(arpc_pkg::REG_PERIOD, 16'd1);
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h7F00_0001, 48'hFEDC_BA98_7654, 2'd1));
        repeat (5) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h7F00_0001, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h7F00_0001, 48'h0000_0000_0001, 2'd3));
        send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        // a longer period: only every third tick sweeps the table
        write_reg(arpc_pkg::REG_PERIOD, 16'd3);
        repeat (7) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
    endtask

    // ttl and period at zero: every tick sweeps, tries climb on each one
    task automatic test_every_tick_sweeps();
        write_reg(arpc_pkg::REG_TTL, 16'd0);
        write_reg(arpc_pkg::REG_PERIOD, 16'd0);
        steady = 1'b1;
        repeat (10) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        steady = 1'b0;
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0));
    endtask

    // random mix in two blocks, each with its own aging setup and pacing
    task automatic test_random_traffic();
        ip_pool[0] = 32'h0000_0001;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'h7F00_0001;
        ip_pool[3] = 32'hC0A8_0101;
        for (int i = 4; i < POOL; i++) ip_pool[i] = 32'($urandom) | 32'h1;
        for (int blk = 0; blk < 2; blk++) begin
            write_reg(arpc_pkg::REG_TTL, 16'($urandom_range(1, 8)));
            write_reg(arpc_pkg::REG_PERIOD, 16'($urandom_range(0, 3)));
            for (int n = 0; n < 20; n++) begin
                if (n % 10 == 0) steady = ($urandom_range(3) == 0);
                send_item(random_item());
            end
            steady = 1'b0;
        end
    endtask

    // fill every slot with fresh addresses, then miss on a full table
    task automatic test_table_full();
        for (int k = 0; k < NSLOTS; k++)
            send_item(mk_item(arpc_pkg::CMD_SET, 32'h0AFE_0001 + 32'(k), 48'(k) << 20,
                              2'(k)));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0BAD_0001, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0BAD_0001, '1, 2'd3));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0, '1, 2'd1));
        send_item(mk_item(arpc_pkg::CMD_SET, 32'h0AFE_0003, 48'hCAFE_0000_BEEF, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0AFE_0003, '0, 2'd0));
    endtask

    // register extremes: top values suppress sweeps and refreshes, zero values bring them back
    task automatic test_config_extremes();
        write_reg(arpc_pkg::REG_TTL, 16'hFFFF);
        write_reg(arpc_pkg::REG_PERIOD, 16'hFFFF);
        repeat (3) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        send_item(mk_item(arpc_pkg::CMD_LOOKUP, 32'h0AFE_0001, '0, 2'd0));
        write_reg(arpc_pkg::REG_PERIOD, 16'h0);
        repeat (3) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        write_reg(arpc_pkg::REG_TTL, 16'h0);
        write_reg(arpc_pkg::REG_PERIOD, 16'hFFFF);
        send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
        write_reg(arpc_pkg::REG_PERIOD, 16'h0);
        repeat (2) send_item(mk_item(arpc_pkg::CMD_TICK, 32'h0, '0, 2'd0));
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_set_and_lookup();
        test_tick_without_check();
        test_aging_refresh();
        test_every_tick_sweeps();
        test_random_traffic();
        test_table_full();
        test_config_extremes();
        settle();
        $display("summary: %0d commands, %0d results checked", items_sent, results_seen);
        $display("summary: %0d refresh requests, %0d full-table answers, %0d mismatches",
                 refreshes_seen, full_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/arpc_pkg.sv
sv/arpc_cell.sv
sv/arpc_head.sv
sv/arp_cache_with_aging_unit.sv
sv/arpc_checker.sv
tb/sv/tb_top.sv
